// ----- hw/rtl/iir_filter_df2t_macros.svh -----
// Assertion macros used by the checker file of the IIR filter.
// Depends on nothing; included by bare file name.
`ifndef IIR_FILTER_DF2T_MACROS_SVH
`define IIR_FILTER_DF2T_MACROS_SVH

// Consequent checked in the clock after the antecedent.
`define IIRDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define IIRDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/iirdf_pkg.sv -----
// Types, constants and arithmetic helpers of the transposed direct form II IIR filter.
// Depends on nothing; imported by every RTL module of the block.
package iirdf_pkg;

	// Delay line depth; the register map carries taps up to order 3, so 1..3.
	localparam int MAX_ORDER = 3;
	localparam int NUM_B     = 4;

	localparam int SMP_W  = 16;
	localparam int COEF_W = 18;
	localparam int Z_W    = 40;
	localparam int PROD_W = COEF_W + SMP_W;
	localparam int ACC_W  = Z_W + 1;
	localparam int UPD_W  = Z_W + 2;
	localparam int RND_SH = 14;

	localparam int ZIDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	// Step schedule: b products on steps 0..MAX_ORDER, a products from PB_START.
	// PB_START waits for y, which is registered on step 2.
	localparam int PB_START  = (MAX_ORDER + 1 > 3) ? MAX_ORDER + 1 : 3;
	localparam int LAST_STEP = PB_START + MAX_ORDER;
	localparam int STEP_W    = $clog2(LAST_STEP + 1);

	typedef logic        [1:0]        order_t;
	typedef logic        [1:0]        sidx_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [Z_W-1:0]    z_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [UPD_W-1:0]  upd_t;
	typedef logic        [ZIDX_W-1:0] zidx_t;
	typedef logic        [STEP_W-1:0] step_t;

	localparam coef_t B0_RESET = coef_t'(16384);

	typedef enum logic [1:0] {
		OP_PROCESS,
		OP_CLEAR,
		OP_LOAD,
		OP_READ
	} opcode_t;

	typedef enum logic [2:0] {
		REG_ORDER,
		REG_B0,
		REG_B1,
		REG_B2,
		REG_B3,
		REG_A1,
		REG_A2,
		REG_A3
	} reg_idx_t;

	typedef struct packed {
		order_t                 order;
		coef_t [NUM_B-1:0]      coef_b;
		coef_t [NUM_B-1:1]      coef_a;
	} coef_set_t;

	function automatic order_t eff_order(input order_t o);
		if (int'(o) > MAX_ORDER)
			return order_t'(MAX_ORDER);
		return o;
	endfunction

	// Round half up by 2^RND_SH, then clamp to the sample range.
	function automatic smp_t round_sat16(input acc_t acc);
		logic signed [ACC_W:0]        biased;
		logic signed [ACC_W-RND_SH:0] q;
		biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (RND_SH - 1));
		q = biased[ACC_W:RND_SH];
		if (q > $signed({{(ACC_W-RND_SH-SMP_W+1){1'b0}}, 1'b0, {(SMP_W-1){1'b1}}}))
			return {1'b0, {(SMP_W-1){1'b1}}};
		if (q < $signed({{(ACC_W-RND_SH-SMP_W+1){1'b1}}, 1'b1, {(SMP_W-1){1'b0}}}))
			return {1'b1, {(SMP_W-1){1'b0}}};
		return q[SMP_W-1:0];
	endfunction

	// Clamp an exact update to the delay element range.
	function automatic z_t sat40(input upd_t v);
		if ((&v[UPD_W-1:Z_W-1]) || !(|v[UPD_W-1:Z_W-1]))
			return v[Z_W-1:0];
		if (v[UPD_W-1])
			return {1'b1, {(Z_W-1){1'b0}}};
		return {1'b0, {(Z_W-1){1'b1}}};
	endfunction

endpackage

// ----- hw/rtl/iirdf_cfg.sv -----
// Configuration register file: filter order and the normalised Q3.14 taps.
// Depends on iirdf_pkg.
module iirdf_cfg import iirdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [COEF_W-1:0] cfg_data,
	output coef_set_t         coefs
);

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.order  <= '0;
			coefs_q.coef_b <= {{(3*COEF_W){1'b0}}, B0_RESET};
			coefs_q.coef_a <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_ORDER: coefs_q.order     <= cfg_data[1:0];
				REG_B0:    coefs_q.coef_b[0] <= cfg_data;
				REG_B1:    coefs_q.coef_b[1] <= cfg_data;
				REG_B2:    coefs_q.coef_b[2] <= cfg_data;
				REG_B3:    coefs_q.coef_b[3] <= cfg_data;
				REG_A1:    coefs_q.coef_a[1] <= cfg_data;
				REG_A2:    coefs_q.coef_a[2] <= cfg_data;
				REG_A3:    coefs_q.coef_a[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

// ----- hw/rtl/iirdf_mac.sv -----
// Shared signed multiplier: Q3.14 tap times Q0.15 sample, product registered.
// Depends on iirdf_pkg.
module iirdf_mac import iirdf_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  coef_t coef,
	input  smp_t  operand,
	output prod_t product_s1
);

	always_ff @(posedge clk) begin
		if (en)
			product_s1 <= coef * operand;
	end

endmodule

// ----- hw/rtl/iir_filter_df2t.sv -----
// Top level of the transposed direct form II IIR filter: sequencer, delay line, output register.
// Depends on iirdf_pkg, iirdf_cfg and iirdf_mac.
//
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------------------------
//  input   | in_valid / in_stall      | opcode, sample_in, state_index, state_value, block_end
//  output  | out_valid / out_stall    | sample_out, state_out, block_end_out
//  config  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A process item is latched at its transfer, then runs LAST_STEP+1 = 8 steps on the one shared
// multiplier (2*MAX_ORDER+1 products) and is handed off before the input reopens. Clear, load
// and read run only step 0 before the hand-off. Reset empties the output register and zeroes
// the delay line and taps (b0 = 1.0, order 0). A held out_stall keeps the result in the output
// register and the next item waits in the hand-off state until the register frees.
module iir_filter_df2t import iirdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic signed [15:0] sample_in,
	input  logic [1:0]        state_index,
	input  logic signed [39:0] state_value,
	input  logic              block_end,

	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [15:0] sample_out,
	output logic signed [39:0] state_out,
	output logic              block_end_out,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [17:0]       cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t    state_q;
	step_t     step_q;
	step_t     last_q;
	logic      out_valid_q;
	smp_t      sample_out_q;
	z_t        state_out_q;
	logic      block_end_out_q;

	opcode_t   op_q;
	smp_t      x_q;
	sidx_t     idx_q;
	z_t        ld_val_q;
	logic      be_q;
	order_t    n_q;
	smp_t      y_q;
	z_t        st_q;
	acc_t      acc_q;
	acc_t      t_q [MAX_ORDER];
	z_t        z_q [MAX_ORDER];

	coef_set_t coefs;
	coef_t     mul_coef;
	smp_t      mul_opnd;
	prod_t     product_s1;
	logic      run;
	logic      accept;
	zidx_t     zr_addr;
	z_t        zr;
	zidx_t     tk;
	zidx_t     zj;
	logic [1:0] bidx;
	logic [1:0] aidx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign run       = (state_q == ST_RUN);

	iirdf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	iirdf_mac u_mac (
		.clk        (clk),
		.en         (run),
		.coef       (mul_coef),
		.operand    (mul_opnd),
		.product_s1 (product_s1)
	);

	assign bidx = step_q[1:0];
	assign aidx = 2'(step_q - STEP_W'(PB_START - 1));
	assign tk   = ZIDX_W'(step_q - STEP_W'(2));
	assign zj   = ZIDX_W'(step_q - STEP_W'(PB_START + 1));

	// Multiplier schedule: b0*x, b1..bn*x, then a1..an*y.
	always_comb begin
		mul_coef = coefs.coef_b[0];
		mul_opnd = x_q;
		if (step_q >= 1 && step_q <= MAX_ORDER) begin
			mul_coef = coefs.coef_b[bidx];
		end else if (step_q >= PB_START && step_q < PB_START + MAX_ORDER) begin
			mul_coef = coefs.coef_a[aidx];
			mul_opnd = y_q;
		end
	end

	// Single read port on the delay line: z[idx] for a read, z0 for y, z[k+1] for the updates.
	always_comb begin
		if (step_q == 0)
			zr_addr = ZIDX_W'(idx_q);
		else if (step_q == 1)
			zr_addr = '0;
		else
			zr_addr = ZIDX_W'(step_q - STEP_W'(1));
	end
	assign zr = z_q[zr_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			step_q          <= '0;
			last_q          <= '0;
			out_valid_q     <= 1'b0;
			sample_out_q    <= '0;
			state_out_q     <= '0;
			block_end_out_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						last_q  <= (opcode_t'(opcode) == OP_PROCESS) ? step_t'(LAST_STEP) : '0;
					end
				end
				ST_RUN: begin
					if (step_q == last_q)
						state_q <= ST_FIN;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_FIN: begin
					// hold until the output register is free or being emptied
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						sample_out_q    <= y_q;
						state_out_q     <= st_q;
						block_end_out_q <= be_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item registers and working values.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode_t'(opcode);
			x_q      <= sample_in;
			idx_q    <= state_index;
			ld_val_q <= state_value;
			be_q     <= block_end;
			n_q      <= eff_order(coefs.order);
			y_q      <= '0;
			st_q     <= '0;
		end
		if (run) begin
			if (step_q == 0 && op_q == OP_READ)
				st_q <= (idx_q < n_q) ? zr : '0;
			if (step_q == 1)
				acc_q <= ((n_q != '0) ? ACC_W'(zr) : '0) + ACC_W'(product_s1);
			if (step_q == 2)
				y_q <= round_sat16(acc_q);
			if (step_q >= 2 && step_q <= MAX_ORDER + 1)
				t_q[tk] <= ((int'(tk) + 1 < int'(n_q)) ? ACC_W'(zr) : '0) + ACC_W'(product_s1);
		end
	end

	// Delay line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++)
				z_q[i] <= '0;
		end else if (run) begin
			if (step_q == 0 && op_q == OP_CLEAR) begin
				for (int i = 0; i < MAX_ORDER; i++)
					z_q[i] <= '0;
			end
			if (step_q == 0 && op_q == OP_LOAD && idx_q < n_q)
				z_q[ZIDX_W'(idx_q)] <= ld_val_q;
			if (op_q == OP_PROCESS && step_q >= PB_START + 1 &&
			    step_q <= PB_START + MAX_ORDER && int'(zj) < int'(n_q))
				z_q[zj] <= sat40(UPD_W'(t_q[zj]) - UPD_W'(product_s1));
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign state_out     = state_out_q;
	assign block_end_out = block_end_out_q;

endmodule

// ----- hw/rtl/iirdf_chk.sv -----
// Port-level checker for the IIR filter, bound to the top level.
// Depends on iir_filter_df2t_macros.svh.
`include "iir_filter_df2t_macros.svh"

module iirdf_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [15:0] sample_out,
	input logic signed [39:0] state_out,
	input logic              block_end_out
);

	// after its transfer, every item keeps the input closed while it runs and while it is handed off
	`IIRDF_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && !in_stall, in_stall ##1 in_stall, "input reopened too early after a transfer")

	// a result appears only after the block was busy with an item
	`IIRDF_ASSERT_NOW(a_result_from_item, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without an item in progress")

	`IIRDF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(state_out) && $stable(block_end_out), "stalled result changed")

endmodule

bind iir_filter_df2t iirdf_chk u_iirdf_chk (.*);
